@@ rtl/kpe_pkg.sv @@
// shared types, widths and constants of the keyspace partition entry block
package kpe_pkg;

	// table limits
	localparam int MAX_STREAMS = 1024;
	localparam int MAX_ROWS    = 16;
	localparam int MAX_POOL    = 256;

	// register widths
	localparam int POOL_W   = 9;
	localparam int ROWCNT_W = 5;
	localparam int STRMCNT_W = 11;

	// field widths
	localparam int STREAM_W = 10;
	localparam int ROW_W    = 4;
	localparam int OFF_W    = 8;

	// datapath widths
	localparam int N_W   = 11;
	localparam int J_W   = 10;
	localparam int DD_W  = N_W + POOL_W;
	localparam int DS_W  = 11;
	localparam int CNT_W = $clog2(DD_W);

	// bus widths
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// saturation limits at register width
	localparam logic [POOL_W-1:0]    POOL_MAX = POOL_W'(MAX_POOL);
	localparam logic [ROWCNT_W-1:0]  ROWS_MAX = ROWCNT_W'(MAX_ROWS);
	localparam logic [STRMCNT_W-1:0] STRM_MAX = STRMCNT_W'(MAX_STREAMS);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT = 2'd2;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SIMPLE,
		OP_LO,
		OP_HI,
		OP_NP,
		OP_BIG,
		OP_J,
		OP_NEXT,
		OP_OUT
	} op_t;

	// divider operand selection
	typedef enum logic [1:0] {
		DSEL_LO,
		DSEL_HI,
		DSEL_NP,
		DSEL_J
	} dsel_t;

	typedef struct packed {
		op_t   op;
		logic  div_start;
		dsel_t div_sel;
	} kpe_cmd_t;

	typedef struct packed {
		logic bad;
		logic n_le1;
		logic n_eq_p;
		logic n_lt_p;
		logic last_row;
		logic div_done;
		logic div_busy;
	} kpe_status_t;

endpackage

@@ rtl/keyspace_partition_entry.sv @@
// top level: configuration registers, controller, datapath and checks
//
// Each query returns one entry of the keyspace partition table: the first
// and last pool offsets held by stream stream_index on character position
// row_index. The entry is worked out row by row from row zero with one
// shared divider that produces one quotient bit per cycle. A row that
// spreads a group over ranges or splits a group larger than the pool takes
// two divider runs; a row with a single stream or a group the size of the
// pool is handled without the divider. When the query lies outside the
// table, no row is worked out, both offsets are zero and in_range is low.
// The next query can be taken in the cycle after the result is loaded. One
// query is in work at a time; a finished result waits in the output
// register while the next query is taken.
// Registers are to be written only while the block is idle; the block
// itself does not enforce this. Index 0 is pool_size, 1 row_count,
// 2 stream_count; other indexes are ignored.
module keyspace_partition_entry
	import kpe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // stream_index[9:0], row_index[13:10]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // first_offset[7:0], last_offset[15:8], in_range[16]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [POOL_W-1:0]    pool_size_q;
	logic [ROWCNT_W-1:0]  row_count_q;
	logic [STRMCNT_W-1:0] stream_count_q;
	kpe_cmd_t             cmd;
	kpe_status_t          status;
	logic [OFF_W-1:0]     first_offset;
	logic [OFF_W-1:0]     last_offset;
	logic                 in_range;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q    <= POOL_W'(26);
			row_count_q    <= ROWCNT_W'(8);
			stream_count_q <= STRMCNT_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POOL_SIZE:    pool_size_q    <= cfg_data[POOL_W-1:0];
				CFG_ROW_COUNT:    row_count_q    <= cfg_data[ROWCNT_W-1:0];
				CFG_STREAM_COUNT: stream_count_q <= cfg_data[STRMCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	kpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	kpe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.pool_size    (pool_size_q),
		.row_count    (row_count_q),
		.stream_count (stream_count_q),
		.stream_index (s_tdata[STREAM_W-1:0]),
		.row_index    (s_tdata[STREAM_W+ROW_W-1:STREAM_W]),
		.first_offset (first_offset),
		.last_offset  (last_offset),
		.in_range     (in_range)
	);

	// result packing
	assign m_tdata = {(OUT_DATA_W - 2 * OFF_W - 1)'(0), in_range, last_offset, first_offset};

	// a query outside the table gives zero offsets
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !in_range |-> first_offset == '0 && last_offset == '0)
		else $error("out-of-range result with nonzero offsets");

	// a range never runs backward
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && in_range |-> first_offset <= last_offset)
		else $error("first offset above last offset");

	// the divider is quiet whenever a new query can be taken
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !status.div_busy && !status.div_done)
		else $error("divider active while idle");

	// one query in work at a time
	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

endmodule

@@ rtl/kpe_div.sv @@
// shared restoring divider, one quotient bit per cycle
module kpe_div
	import kpe_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DD_W-1:0] dividend,
	input  logic [DS_W-1:0] divisor,
	output logic [DD_W-1:0] quot,
	output logic [DS_W-1:0] rem,
	output logic            busy,
	output logic            done
);

	logic [DD_W-1:0]  quo_q;
	logic [DS_W-1:0]  rem_q;
	logic [DS_W-1:0]  div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DS_W:0]    trial;
	logic             fits;

	// trial subtraction of one step
	always_comb begin
		trial = {rem_q, quo_q[DD_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DD_W-2:0], fits};
			rem_q <= fits ? DS_W'(trial - {1'b0, div_q}) : trial[DS_W-1:0];
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ rtl/kpe_dp.sv @@
// datapath: group size, position, offsets and result register
module kpe_dp
	import kpe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  kpe_cmd_t              cmd,
	output kpe_status_t           status,
	input  logic [POOL_W-1:0]     pool_size,
	input  logic [ROWCNT_W-1:0]   row_count,
	input  logic [STRMCNT_W-1:0]  stream_count,
	input  logic [STREAM_W-1:0]   stream_index,
	input  logic [ROW_W-1:0]      row_index,
	output logic [OFF_W-1:0]      first_offset,
	output logic [OFF_W-1:0]      last_offset,
	output logic                  in_range
);

	logic [POOL_W-1:0]    p_eff;
	logic [ROWCNT_W-1:0]  rows_eff;
	logic [STRMCNT_W-1:0] strm_eff;
	logic                 bad;

	logic [POOL_W-1:0] p_q;
	logic [N_W-1:0]    n_q;
	logic [J_W-1:0]    j_q;
	logic [ROW_W-1:0]  rows_left_q;
	logic [OFF_W-1:0]  first_q;
	logic [OFF_W-1:0]  last_q;
	logic              valid_q;
	logic [N_W-1:0]    q_q;
	logic [POOL_W-1:0] rm_q;
	logic [N_W-1:0]    big_q;
	logic              lt_q;
	logic [OFF_W-1:0]  out_first_q;
	logic [OFF_W-1:0]  out_last_q;
	logic              out_valid_q;

	logic [N_W-1:0]  j_ext;
	logic [N_W-1:0]  j_inc;
	logic [N_W-1:0]  q_inc;
	logic [DD_W-1:0] prod;
	logic [DD_W-1:0] big_prod;
	logic            jb_lt;
	logic [DD_W-1:0] dividend;
	logic [DS_W-1:0] divisor;
	logic [DD_W-1:0] quot;
	logic [DS_W-1:0] rem;
	logic            div_done;
	logic            div_busy;
	logic [OFF_W-1:0] v;

	// clamp registers and check the query against the table
	always_comb begin
		if (pool_size == '0)
			p_eff = POOL_W'(1);
		else if (pool_size > POOL_MAX)
			p_eff = POOL_MAX;
		else
			p_eff = pool_size;
		rows_eff = (row_count > ROWS_MAX) ? ROWS_MAX : row_count;
		strm_eff = (stream_count > STRM_MAX) ? STRM_MAX : stream_count;
		bad = (STRMCNT_W'(stream_index) >= strm_eff) || (ROWCNT_W'(row_index) >= rows_eff);
	end

	// divider operands
	always_comb begin
		j_ext    = N_W'(j_q);
		j_inc    = j_ext + 1'b1;
		q_inc    = q_q + 1'b1;
		jb_lt    = j_ext < big_q;
		prod     = ((cmd.div_sel == DSEL_HI) ? DD_W'(j_inc) : DD_W'(j_ext)) * DD_W'(p_q);
		big_prod = DD_W'(rm_q) * DD_W'(q_inc);
		dividend = prod;
		divisor  = n_q;
		case (cmd.div_sel) inside
			DSEL_LO, DSEL_HI: begin
				dividend = prod;
				divisor  = n_q;
			end
			DSEL_NP: begin
				dividend = DD_W'(n_q);
				divisor  = DS_W'(p_q);
			end
			default: begin
				dividend = jb_lt ? DD_W'(j_ext) : DD_W'(j_ext - big_q);
				divisor  = jb_lt ? q_inc : q_q;
			end
		endcase
		v = lt_q ? quot[OFF_W-1:0] : OFF_W'(rm_q) + quot[OFF_W-1:0];
	end

	kpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quot     (quot),
		.rem      (rem),
		.busy     (div_busy),
		.done     (div_done)
	);

	// per-row state update
	always_ff @(posedge clk) begin
		if (cmd.div_start && cmd.div_sel == DSEL_J)
			lt_q <= jb_lt;
		case (cmd.op)
			OP_LOAD: begin
				p_q         <= p_eff;
				n_q         <= N_W'(strm_eff);
				j_q         <= stream_index;
				// a query outside the table walks no rows
				rows_left_q <= bad ? '0 : row_index;
				first_q     <= '0;
				last_q      <= bad ? '0 : OFF_W'(p_eff - 1'b1);
				valid_q     <= !bad;
			end
			OP_SIMPLE: begin
				if (n_q <= N_W'(1)) begin
					first_q <= '0;
					last_q  <= OFF_W'(p_q - 1'b1);
				end else begin
					first_q <= j_q[OFF_W-1:0];
					last_q  <= j_q[OFF_W-1:0];
				end
				n_q <= N_W'(1);
				j_q <= '0;
			end
			OP_LO: first_q <= quot[OFF_W-1:0];
			OP_HI: begin
				last_q <= quot[OFF_W-1:0] - 1'b1;
				n_q    <= N_W'(1);
				j_q    <= '0;
			end
			OP_NP: begin
				q_q  <= quot[N_W-1:0];
				rm_q <= rem[POOL_W-1:0];
			end
			OP_BIG: big_q <= big_prod[N_W-1:0];
			OP_J: begin
				first_q <= v;
				last_q  <= v;
				j_q     <= rem[J_W-1:0];
				n_q     <= lt_q ? q_inc : q_q;
			end
			OP_NEXT: rows_left_q <= rows_left_q - 1'b1;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_first_q <= first_q;
			out_last_q  <= last_q;
			out_valid_q <= valid_q;
		end
	end

	// status to the controller
	always_comb begin
		status.bad      = bad;
		status.n_le1    = n_q <= N_W'(1);
		status.n_eq_p   = n_q == N_W'(p_q);
		status.n_lt_p   = n_q < N_W'(p_q);
		status.last_row = rows_left_q == '0;
		status.div_done = div_done;
		status.div_busy = div_busy;
	end

	assign first_offset = out_first_q;
	assign last_offset  = out_last_q;
	assign in_range     = out_valid_q;

endmodule

@@ rtl/kpe_ctrl.sv @@
// controller: sequences rows and divider runs, owns both handshakes
module kpe_ctrl
	import kpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  kpe_status_t status,
	output kpe_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_ROW     = 9'b000000010,
		ST_DIV_LO  = 9'b000000100,
		ST_DIV_HI  = 9'b000001000,
		ST_DIV_NP  = 9'b000010000,
		ST_MUL_BIG = 9'b000100000,
		ST_SPLIT   = 9'b001000000,
		ST_DIV_J   = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   load_out;

	// next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DSEL_LO;
		in_ready      = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = status.bad ? ST_DONE : ST_ROW;
				end
			end
			ST_ROW: begin
				if (status.n_le1 || status.n_eq_p) begin
					cmd.op  = OP_SIMPLE;
					state_d = ST_DONE;
				end else if (status.n_lt_p) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_LO;
					state_d       = ST_DIV_LO;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_NP;
					state_d       = ST_DIV_NP;
				end
			end
			ST_DIV_LO: begin
				if (status.div_done) begin
					cmd.op        = OP_LO;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_HI;
					state_d       = ST_DIV_HI;
				end
			end
			ST_DIV_HI: begin
				if (status.div_done) begin
					cmd.op  = OP_HI;
					state_d = ST_DONE;
				end
			end
			ST_DIV_NP: begin
				if (status.div_done) begin
					cmd.op  = OP_NP;
					state_d = ST_MUL_BIG;
				end
			end
			ST_MUL_BIG: begin
				cmd.op  = OP_BIG;
				state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_J;
				state_d       = ST_DIV_J;
			end
			ST_DIV_J: begin
				if (status.div_done) begin
					cmd.op  = OP_J;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// a row is finished here; unless it was the asked one, the next row follows
				if (!status.last_row) begin
					cmd.op  = OP_NEXT;
					state_d = ST_ROW;
				end else if (!out_valid_q || out_ready) begin
					cmd.op   = OP_OUT;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
